### design/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// shared constants and types for the lzw encoder unit
// ----------------------------------------------------------------------------
`default_nettype none

package lzwe_pkg;

    localparam int DICT_SIZE = 4096;
    localparam int CODE_W    = $clog2(DICT_SIZE);
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = CODE_W + BYTE_W;
    localparam int OUT_W     = 12;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CODE_W-1:0] NO_CODE        = CODE_W'(DICT_SIZE - 1);
    localparam logic [CODE_W-1:0] LAST_BYTE_CODE = CODE_W'(255);

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

endpackage

`default_nettype wire

### design/lzwe_dict.sv
// ----------------------------------------------------------------------------
// lzwe_dict
// child table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_dict (
    input  wire                               i_clk,
    input  wire lzwe_pkg::t_wr_req            i_wr,
    input  wire                               i_rd_en,
    input  wire [lzwe_pkg::ADDR_W-1:0]        i_rd_addr,
    output logic [lzwe_pkg::CODE_W-1:0]       o_rd_data
);

    localparam int DEPTH = 1 << lzwe_pkg::ADDR_W;

    logic [lzwe_pkg::CODE_W-1:0] r_mem [DEPTH];
    logic [lzwe_pkg::CODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/lzwe_out_fifo.sv
// ----------------------------------------------------------------------------
// lzwe_out_fifo
// small result queue, takes up to two words a cycle and hands out one unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_out_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire lzwe_pkg::t_push i_push,
    output logic                 o_room_two,
    output logic                 o_valid,
    output lzwe_pkg::t_res       o_res,
    input  wire                  i_stall
);

    localparam int PTR_W = $clog2(lzwe_pkg::FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    lzwe_pkg::t_res   r_ent [lzwe_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             pop;

    assign pop = (r_count != '0) && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_ent[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_ent[r_wr_ptr + PTR_W'(1)] <= i_push.r1;
        end
    end

    assign o_room_two = (r_count <= CNT_W'(lzwe_pkg::FIFO_DEPTH - 2));
    assign o_valid    = (r_count != '0);
    assign o_res      = r_ent[r_rd_ptr];

endmodule

`default_nettype wire

### design/lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzw_encoder_unit
// fixed-width lzw encoder with child table in a synchronous memory
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  input    in   i_valid/o_stall    i_operation, i_data_byte
//  output   out  o_valid/i_stall    o_code_out, o_last_of_run
//
//  a byte that needs a table lookup takes a memory read, then the hit update or
//  miss writeback, or flush when full; no-prefix bytes and finish need no read
//  after reset and whenever the dictionary fills, a clearing pass writes
//  the empty mark into all 2^20 entries, one a cycle; input stalls meanwhile
//  results go through a 4-word queue; input is taken while it has room for two
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_encoder_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_operation,
    input  wire [lzwe_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [lzwe_pkg::OUT_W-1:0]  o_code_out,
    output logic                        o_last_of_run
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [lzwe_pkg::CODE_W-1:0]   r_prefix, n_prefix;
    logic [lzwe_pkg::CODE_W-1:0]   r_next_code, n_next_code;
    logic [lzwe_pkg::BYTE_W-1:0]   r_byte, n_byte;
    logic [lzwe_pkg::ADDR_W-1:0]   r_clr_addr, n_clr_addr;

    lzwe_pkg::t_wr_req             wr;
    lzwe_pkg::t_push               push;
    lzwe_pkg::t_res                out_res;
    logic                          rd_en;
    logic [lzwe_pkg::ADDR_W-1:0]   rd_addr;
    logic [lzwe_pkg::CODE_W-1:0]   rd_data;
    logic [lzwe_pkg::CODE_W-1:0]   code_inc;
    logic                          room_two;
    logic                          in_acc;

    assign o_stall  = !((r_state == S_IDLE) && room_two);
    assign in_acc   = i_valid && !o_stall;
    assign rd_addr  = {r_prefix, i_data_byte};
    assign code_inc = r_next_code + lzwe_pkg::CODE_W'(1);

    always_comb begin
        n_state     = r_state;
        n_prefix    = r_prefix;
        n_next_code = r_next_code;
        n_byte      = r_byte;
        n_clr_addr  = r_clr_addr;
        wr          = '0;
        push        = '0;
        rd_en       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr.en      = 1'b1;
                wr.addr    = r_clr_addr;
                wr.data    = lzwe_pkg::NO_CODE;
                n_clr_addr = r_clr_addr + lzwe_pkg::ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == lzwe_pkg::OP_FINISH) begin
                        push.cnt     = 2'd2;
                        push.r0.code = r_prefix;
                        push.r0.last = 1'b0;
                        push.r1.code = lzwe_pkg::NO_CODE;
                        push.r1.last = 1'b1;
                    end else if (r_prefix == lzwe_pkg::NO_CODE) begin
                        n_prefix = lzwe_pkg::CODE_W'(i_data_byte);
                    end else begin
                        rd_en   = 1'b1;
                        n_byte  = i_data_byte;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
                if (rd_data != lzwe_pkg::NO_CODE) begin
                    n_prefix = rd_data;
                end else if (code_inc == lzwe_pkg::NO_CODE) begin
                    // dictionary full: flush prefix and raw byte, then wipe
                    push.cnt     = 2'd2;
                    push.r0.code = r_prefix;
                    push.r0.last = 1'b0;
                    push.r1.code = lzwe_pkg::CODE_W'(r_byte);
                    push.r1.last = 1'b1;
                    n_next_code  = lzwe_pkg::LAST_BYTE_CODE;
                    n_prefix     = lzwe_pkg::NO_CODE;
                    n_clr_addr   = '0;
                    n_state      = S_CLEAR;
                end else begin
                    push.cnt     = 2'd1;
                    push.r0.code = r_prefix;
                    push.r0.last = 1'b1;
                    wr.en        = 1'b1;
                    wr.addr      = {r_prefix, r_byte};
                    wr.data      = code_inc;
                    n_next_code  = code_inc;
                    n_prefix     = lzwe_pkg::CODE_W'(r_byte);
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_prefix    <= lzwe_pkg::NO_CODE;
            r_next_code <= lzwe_pkg::LAST_BYTE_CODE;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_prefix    <= n_prefix;
            r_next_code <= n_next_code;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    lzwe_dict u_dict (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lzwe_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room_two (room_two),
        .o_valid    (o_valid),
        .o_res      (out_res),
        .i_stall    (i_stall)
    );

    assign o_code_out    = lzwe_pkg::OUT_W'(out_res.code);
    assign o_last_of_run = out_res.last;

`ifndef SYNTHESIS
    // a lookup cycle always follows the read issued from idle
    a_look_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> ($past(r_state) == S_IDLE))
        else $error("lookup state entered without a read");

    // the prefix is either none or a code already assigned
    a_prefix_assigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            ((r_prefix == lzwe_pkg::NO_CODE) || (r_prefix <= r_next_code)))
        else $error("prefix refers to an unassigned code");

    // leaving the clearing pass, the dictionary starts empty
    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLEAR && r_state == S_IDLE) |->
            ((r_prefix == lzwe_pkg::NO_CODE) &&
             (r_next_code == lzwe_pkg::LAST_BYTE_CODE)))
        else $error("dictionary state not restarted after clear");
`endif

endmodule

`default_nettype wire
